### rtl/core/fbde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde_pkg
// Shared types and constants of the page frame buffer draw engine.
// ----------------------------------------------------------------------------
package fbde_pkg;

	// command codes
	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_PIXEL = 3'd1;
	localparam logic [2:0] OP_RECT  = 3'd2;
	localparam logic [2:0] OP_BLIT  = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_IMAGE_LEFT   = 2'd2;
	localparam logic [1:0] REG_IMAGE_TOP    = 2'd3;

	// bitmap size limits, also the register reset values
	localparam logic [7:0] MAX_IMG_W = 8'd128;
	localparam logic [6:0] MAX_IMG_H = 7'd64;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] end_x;
		logic [7:0] end_y;
		logic [7:0] bitmap_byte;
		logic [9:0] read_index;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       image_done;
	} rsp_t;

	typedef struct packed {
		logic [7:0] image_width;
		logic [6:0] image_height;
		logic [7:0] image_left;
		logic [7:0] image_top;
	} cfg_t;

endpackage

### rtl/core/fbde_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde_store
// Frame store memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbde_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/fbde_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde_engine
// Command sequencer around one shared pixel address / mask unit that drives
// read-modify-write cycles on the frame store. Also keeps the bitmap cursor.
// ----------------------------------------------------------------------------
module fbde_engine #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64,
	parameter int STORE_BYTES   = 1024,
	parameter int AW            = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  fbde_pkg::cmd_t   cmd,
	input  fbde_pkg::cfg_t   cfg,
	input  logic             cfg_we,
	output logic             ready,
	output logic             fin,
	input  logic             fin_ack,
	output fbde_pkg::rsp_t   rsp,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  logic [7:0]       rd_data,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [7:0]       wr_data
);

	localparam int SWW = $clog2(SCREEN_WIDTH + 1);
	localparam int IDXW = SWW + 6;
	localparam logic [4:0] LAST_PAGE = 5'((SCREEN_HEIGHT - 1) / 8);
	localparam logic [7:0] LAST_COL = 8'(SCREEN_WIDTH - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_RECT    = 4'd2;
	localparam logic [3:0] S_RECT_WR = 4'd3;
	localparam logic [3:0] S_BIT     = 4'd4;
	localparam logic [3:0] S_BIT_WR  = 4'd5;
	localparam logic [3:0] S_READ    = 4'd6;
	localparam logic [3:0] S_RDATA   = 4'd7;
	localparam logic [3:0] S_FINISH  = 4'd8;

	// control
	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic          clr_rsp_q;
	logic [3:0]    blit_col_q;
	logic [5:0]    blit_row_q;
	logic [7:0]    cur_x_q;
	logic [4:0]    page_q;
	logic [2:0]    bit_q;

	// payload
	fbde_pkg::rsp_t rsp_q;
	logic [7:0]    col_end_q;
	logic [4:0]    page_start_q;
	logic [4:0]    page_end_q;
	logic [4:0]    ey_page_q;
	logic [2:0]    py_lo_q;
	logic [2:0]    ey_lo_q;
	logic [7:0]    bits_q;
	logic [7:0]    base_x_q;
	logic [6:0]    col_base_q;
	logic [7:0]    w_q;
	logic [7:0]    row_y_q;
	logic          draw_row_q;
	logic [AW-1:0] ridx_q;
	logic          rd_ok_q;
	logic [AW-1:0] wa_q;
	logic [7:0]    mask_q;

	// bitmap cursor math for the command being accepted
	logic [7:0] w_clip;
	logic [6:0] h_clip;
	logic [4:0] per_row;
	logic [6:0] rows;
	logic [3:0] col_cur;
	logic [5:0] row_cur;
	logic [4:0] col_inc;
	logic [6:0] row_inc;
	logic [3:0] col_nx;
	logic [5:0] row_nx;
	logic       blit_done;

	always_comb begin
		w_clip = (cfg.image_width > fbde_pkg::MAX_IMG_W) ? fbde_pkg::MAX_IMG_W
			: cfg.image_width;
		h_clip = (cfg.image_height > fbde_pkg::MAX_IMG_H) ? fbde_pkg::MAX_IMG_H
			: cfg.image_height;
		per_row = 5'((9'(w_clip) + 9'd7) >> 3);
		if (per_row == 5'd0) begin
			per_row = 5'd1;
		end
		rows = (h_clip == 7'd0) ? 7'd1 : h_clip;
		col_cur = ({1'b0, blit_col_q} >= per_row) ? 4'd0 : blit_col_q;
		row_cur = ({1'b0, blit_row_q} >= rows) ? 6'd0 : blit_row_q;
		col_inc = {1'b0, col_cur} + 5'd1;
		row_inc = {1'b0, row_cur} + 7'd1;
		blit_done = 1'b0;
		col_nx = col_inc[3:0];
		row_nx = row_cur;
		if (col_inc >= per_row) begin
			col_nx = 4'd0;
			if (row_inc >= rows) begin
				row_nx = 6'd0;
				blit_done = 1'b1;
			end else begin
				row_nx = row_inc[5:0];
			end
		end
	end

	// rectangle setup; a single pixel is a one-by-one rectangle
	logic [7:0] rx_end;
	logic [7:0] ry_end;
	logic       rect_empty;
	logic [7:0] rect_col_end;
	logic [4:0] rect_page_end;

	always_comb begin
		rx_end = (cmd.op == fbde_pkg::OP_PIXEL) ? cmd.pos_x : cmd.end_x;
		ry_end = (cmd.op == fbde_pkg::OP_PIXEL) ? cmd.pos_y : cmd.end_y;
		rect_empty = (rx_end < cmd.pos_x) || (ry_end < cmd.pos_y)
			|| (9'(cmd.pos_x) >= 9'(SCREEN_WIDTH))
			|| (9'(cmd.pos_y) >= 9'(SCREEN_HEIGHT));
		rect_col_end = (9'(rx_end) < 9'(SCREEN_WIDTH)) ? rx_end : LAST_COL;
		rect_page_end = (ry_end[7:3] > LAST_PAGE) ? LAST_PAGE : ry_end[7:3];
	end

	// shared address / mask unit
	logic            in_bit;
	logic [7:0]      x_sel;
	logic [7:0]      y_sel;
	logic [2:0]      lo;
	logic [2:0]      hi;
	logic [7:0]      mask;
	logic [IDXW-1:0] idx;
	logic            hit;
	logic            bit_en;
	logic            go_rmw;

	always_comb begin
		in_bit = (state_q == S_BIT);
		x_sel = in_bit ? (base_x_q + {5'd0, bit_q}) : cur_x_q;
		y_sel = in_bit ? row_y_q : {page_q, 3'd0};
		if (in_bit) begin
			lo = row_y_q[2:0];
			hi = row_y_q[2:0];
		end else begin
			lo = (page_q == page_start_q) ? py_lo_q : 3'd0;
			hi = (page_q == ey_page_q) ? ey_lo_q : 3'd7;
		end
		for (int b = 0; b < 8; b++) begin
			mask[b] = (3'(b) >= lo) && (3'(b) <= hi)
				&& ({1'b0, y_sel[7:3], 3'(b)} < 9'(SCREEN_HEIGHT));
		end
		idx = IDXW'(y_sel[7:3]) * IDXW'(SCREEN_WIDTH) + IDXW'(x_sel);
		hit = (mask != 8'd0) && (9'(x_sel) < 9'(SCREEN_WIDTH))
			&& (32'(idx) < 32'(STORE_BYTES));
		bit_en = draw_row_q && bits_q[bit_q]
			&& ({1'b0, col_base_q + {4'd0, bit_q}} < w_q);
		go_rmw = hit && (state_q == S_RECT || (in_bit && bit_en));
	end

	logic rect_last_page;
	logic rect_last;
	assign rect_last_page = (page_q == page_end_q);
	assign rect_last = rect_last_page && (cur_x_q == col_end_q);

	// store ports
	always_comb begin
		rd_en = go_rmw || (state_q == S_READ);
		rd_addr = (state_q == S_READ) ? ridx_q : AW'(idx);
		wr_en = (state_q == S_CLEAR) || (state_q == S_RECT_WR) || (state_q == S_BIT_WR);
		wr_addr = (state_q == S_CLEAR) ? clr_q : wa_q;
		wr_data = (state_q == S_CLEAR) ? 8'd0 : (rd_data | mask_q);
	end

	assign ready = (state_q == S_IDLE);
	assign fin = (state_q == S_FINISH);
	assign rsp = rsp_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			clr_rsp_q <= 1'b0;
			blit_col_q <= 4'd0;
			blit_row_q <= 6'd0;
			cur_x_q <= 8'd0;
			page_q <= 5'd0;
			bit_q <= 3'd0;
		end else begin
			if (cfg_we) begin
				blit_col_q <= 4'd0;
				blit_row_q <= 6'd0;
			end else if (start && cmd.op == fbde_pkg::OP_BLIT) begin
				blit_col_q <= col_nx;
				blit_row_q <= row_nx;
			end
			case (state_q)
				S_CLEAR: begin
					if (clr_q == LAST_ADDR) begin
						clr_q <= '0;
						state_q <= clr_rsp_q ? S_FINISH : S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						case (cmd.op)
							fbde_pkg::OP_CLEAR: begin
								clr_rsp_q <= 1'b1;
								state_q <= S_CLEAR;
							end
							fbde_pkg::OP_PIXEL, fbde_pkg::OP_RECT: begin
								cur_x_q <= cmd.pos_x;
								page_q <= cmd.pos_y[7:3];
								state_q <= rect_empty ? S_FINISH : S_RECT;
							end
							fbde_pkg::OP_BLIT: begin
								bit_q <= 3'd0;
								state_q <= S_BIT;
							end
							fbde_pkg::OP_READ: state_q <= S_READ;
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_RECT, S_RECT_WR: begin
					if (state_q == S_RECT && go_rmw) begin
						state_q <= S_RECT_WR;
					end else begin
						state_q <= rect_last ? S_FINISH : S_RECT;
						if (rect_last_page) begin
							page_q <= page_start_q;
							cur_x_q <= cur_x_q + 8'd1;
						end else begin
							page_q <= page_q + 5'd1;
						end
					end
				end
				S_BIT, S_BIT_WR: begin
					if (state_q == S_BIT && go_rmw) begin
						state_q <= S_BIT_WR;
					end else begin
						bit_q <= bit_q + 3'd1;
						state_q <= (bit_q == 3'd7) ? S_FINISH : S_BIT;
					end
				end
				S_READ: state_q <= S_RDATA;
				S_RDATA: state_q <= S_FINISH;
				S_FINISH: begin
					if (fin_ack) begin
						clr_rsp_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working operands and the result
	always_ff @(posedge clk) begin
		if (go_rmw) begin
			wa_q <= AW'(idx);
			mask_q <= mask;
		end
		if (state_q == S_RDATA) begin
			rsp_q.read_data <= rd_ok_q ? rd_data : 8'd0;
		end
		if (state_q == S_IDLE && start) begin
			rsp_q.read_data <= 8'd0;
			rsp_q.image_done <= (cmd.op == fbde_pkg::OP_BLIT) && blit_done;
			col_end_q <= rect_col_end;
			page_start_q <= cmd.pos_y[7:3];
			page_end_q <= rect_page_end;
			ey_page_q <= ry_end[7:3];
			py_lo_q <= cmd.pos_y[2:0];
			ey_lo_q <= ry_end[2:0];
			bits_q <= cmd.bitmap_byte;
			base_x_q <= cfg.image_left + {1'b0, col_cur, 3'd0};
			col_base_q <= {col_cur, 3'd0};
			w_q <= w_clip;
			row_y_q <= cfg.image_top + {2'd0, row_cur};
			draw_row_q <= ({1'b0, row_cur} < h_clip);
			ridx_q <= AW'(cmd.read_index);
			rd_ok_q <= (32'(cmd.read_index) < 32'(STORE_BYTES));
		end
	end

endmodule

### rtl/core/page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Monochrome page-layout frame store with clear, pixel, rectangle fill,
// bitmap byte placement and byte read commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd (valid/stall) carries one command per transaction; rsp (valid/stall)
//   returns exactly one response per command: the store byte for a read,
//   the image-done flag for a bitmap byte, zeros otherwise.
//   cfg_we/cfg_index/cfg_data write the bitmap registers (width, height,
//   left, top); any write homes the bitmap cursor. Write only while idle.
//   One command is in work at a time; cmd_stall is high meanwhile. A pixel,
//   rectangle or bitmap command reads each store byte that it touches and
//   writes it back with the mask bits set; clear writes zeros without a read.
//   After reset the store is swept to zero with cmd_stall high. A finished
//   response waits in an output register while rsp_stall is high; the next
//   command may be accepted meanwhile, but its response is held back until
//   the register is free.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64,
	parameter int STORE_BYTES   = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  fbde_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output fbde_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [7:0]      cfg_data
);

	localparam int AW = $clog2(STORE_BYTES);

	fbde_pkg::cfg_t cfg_q;
	fbde_pkg::rsp_t rsp_q;
	fbde_pkg::rsp_t eng_rsp;
	logic           rsp_valid_q;
	logic           eng_ready;
	logic           eng_fin;
	logic           fin_ack;
	logic           start;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic [7:0]     rd_data;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [7:0]     wr_data;

	assign cmd_stall = !eng_ready;
	assign start = cmd_valid && eng_ready;
	assign fin_ack = eng_fin && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width <= fbde_pkg::MAX_IMG_W;
			cfg_q.image_height <= fbde_pkg::MAX_IMG_H;
			cfg_q.image_left <= 8'd0;
			cfg_q.image_top <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				fbde_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width <= cfg_data;
				fbde_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[6:0];
				fbde_pkg::REG_IMAGE_LEFT:   cfg_q.image_left <= cfg_data;
				fbde_pkg::REG_IMAGE_TOP:    cfg_q.image_top <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_ack) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_ack) begin
			rsp_q <= eng_rsp;
		end
	end

	fbde_engine #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.STORE_BYTES   (STORE_BYTES),
		.AW            (AW)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.cfg     (cfg_q),
		.cfg_we  (cfg_we),
		.ready   (eng_ready),
		.fin     (eng_fin),
		.fin_ack (fin_ack),
		.rsp     (eng_rsp),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	fbde_store #(
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule
